@@ rtl/core/lrsr_pkg.sv @@
// Package for the LR shift-reduce engine: sizes, table entry layout,
// opcodes, entry kinds and result event codes.
// Used by lr_shift_reduce_engine; depends on nothing.
package lrsr_pkg;

    localparam int STATE_COUNT  = 512;
    localparam int SYMBOL_COUNT = 128;
    localparam int STACK_DEPTH  = 256;

    localparam int STATE_W    = $clog2(STATE_COUNT);
    localparam int SYM_W      = $clog2(SYMBOL_COUNT);
    localparam int TBL_AW     = STATE_W + SYM_W;
    localparam int TABLE_SIZE = STATE_COUNT * SYMBOL_COUNT;
    localparam int STK_AW     = $clog2(STACK_DEPTH);
    localparam int SP_W       = $clog2(STACK_DEPTH + 1);

    localparam int WORD_W   = 25;
    localparam int FSYM_W   = 7;
    localparam int FSTATE_W = 9;
    localparam int RULE_W   = 10;
    localparam int POPS_W   = 5;
    localparam int LIMIT_W  = 6;
    localparam int ADDR_W   = 16;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd63;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_TOKEN   = 2'd1,
        OP_RESTART = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SHIFT  = 2'd1,
        KIND_REDUCE = 2'd2,
        KIND_GOTO   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        EV_SHIFT     = 3'd0,
        EV_REDUCE    = 3'd1,
        EV_ACCEPT    = 3'd2,
        EV_SYNTAX    = 3'd3,
        EV_OVERFLOW  = 3'd4,
        EV_UNDERFLOW = 3'd5,
        EV_LIMIT     = 3'd6,
        EV_IDLE      = 3'd7
    } event_t;

    localparam logic REG_START_STATE  = 1'b0;
    localparam logic REG_REDUCE_LIMIT = 1'b1;

endpackage

@@ rtl/core/lr_shift_reduce_engine.sv @@
// Top level of the LR shift-reduce engine: action table memory, state stack
// memory, and the sequencer that walks each token's reduce chain.
// Depends on lrsr_pkg.
//
// After reset the engine sweeps the 65536-entry action table to zero, one
// entry per cycle, and accepts no item during the sweep (register writes
// are taken throughout). A token passes through acceptance, a table read and
// a decision when it shifts or stops on its first action. Every reduce that
// completes with its goto push needs a table read for its action, a stack
// read for the uncovered state and a second table read for the goto, all on
// the single read port of each memory. A chain that ends in an accept stops
// after the stack read, one that ends at the goto lookup (missing goto or
// full stack) stops after the goto read, and one that ends on an underflow
// or the reduce limit stops at the decision on its action. A token that
// arrives while no parse runs gets its result without a table read. A state
// that emits a result waits while the result cannot enter the occupied
// output register. The engine does not accept the next item until the
// token's final result has been placed in the output register; a result may
// wait there while the next item is accepted.
module lr_shift_reduce_engine
(
    input  logic                          clk,
    input  logic                          rst_n,

    // APB register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,

    // Input items.
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: table_address[15:0], table_word[40:16], token_symbol[47:41].
    input  logic [lrsr_pkg::S_DATA_W-1:0] s_axis_tdata,
    // tuser: opcode[1:0].
    input  logic [1:0]                    s_axis_tuser,

    // Result items.
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: rule_id[9:0], pop_count[14:10], symbol[21:15], top_state[30:22],
    // stack_level[39:31].
    output logic [lrsr_pkg::M_DATA_W-1:0] m_axis_tdata,
    // tuser: event_res[2:0].
    output logic [2:0]                    m_axis_tuser,
    output logic                          m_axis_tlast
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOOK = 5'b00010,
        ST_ACT  = 5'b00100,
        ST_TOP  = 5'b01000,
        ST_GOTO = 5'b10000
    } state_t;

    localparam int STATE_W = lrsr_pkg::STATE_W;
    localparam int SP_W    = lrsr_pkg::SP_W;
    localparam int STK_AW  = lrsr_pkg::STK_AW;
    localparam int TBL_AW  = lrsr_pkg::TBL_AW;
    localparam int WORD_W  = lrsr_pkg::WORD_W;

    state_t                              state_reg, state_next;
    logic                                clr_reg, clr_next;
    logic [TBL_AW-1:0]                   clr_addr_reg, clr_addr_next;
    logic                                running_reg, running_next;
    logic [SP_W-1:0]                     sp_reg, sp_next;
    logic [STATE_W-1:0]                  top_reg, top_next;
    logic [lrsr_pkg::LIMIT_W-1:0]        done_reg, done_next;
    logic [lrsr_pkg::FSYM_W-1:0]         tok_reg, tok_next;
    logic [lrsr_pkg::RULE_W-1:0]         rule_reg, rule_next;
    logic [lrsr_pkg::POPS_W-1:0]         pops_reg, pops_next;
    logic [lrsr_pkg::FSYM_W-1:0]         lhs_reg, lhs_next;
    logic                                acc_reg, acc_next;
    logic [STATE_W-1:0]                  start_state_reg;
    logic [lrsr_pkg::LIMIT_W-1:0]        reduce_limit_reg;

    logic                                m_valid_reg;
    logic [lrsr_pkg::M_DATA_W-1:0]       m_data_reg;
    logic [2:0]                          m_user_reg;
    logic                                m_last_reg;

    logic [WORD_W-1:0]                   tbl_mem [lrsr_pkg::TABLE_SIZE];
    logic [WORD_W-1:0]                   tbl_rdata;
    logic                                tbl_wr_en, tbl_rd_en;
    logic [TBL_AW-1:0]                   tbl_wr_addr, tbl_rd_addr;
    logic [WORD_W-1:0]                   tbl_wr_data;

    logic [STATE_W-1:0]                  stk_mem [lrsr_pkg::STACK_DEPTH];
    logic [STATE_W-1:0]                  stk_rdata;
    logic                                stk_wr_en, stk_rd_en;
    logic [STK_AW-1:0]                   stk_wr_addr, stk_rd_addr;
    logic [STATE_W-1:0]                  stk_wr_data;

    logic                                in_acc;
    logic                                out_free;
    logic                                emit;
    lrsr_pkg::event_t                    e_ev;
    logic [lrsr_pkg::RULE_W-1:0]         e_rule;
    logic [lrsr_pkg::POPS_W-1:0]         e_pops;
    logic [lrsr_pkg::FSYM_W-1:0]         e_sym;
    logic                                e_last;

    logic [lrsr_pkg::ADDR_W-1:0]         in_addr;
    logic [WORD_W-1:0]                   in_word;
    logic [lrsr_pkg::FSYM_W-1:0]         in_tok;
    lrsr_pkg::opcode_t                   in_op;

    lrsr_pkg::kind_t                     act_kind;
    logic                                act_acc;
    logic [lrsr_pkg::POPS_W-1:0]         act_pops;
    logic [lrsr_pkg::FSYM_W-1:0]         act_lhs;
    logic [lrsr_pkg::RULE_W-1:0]         act_rule;
    logic [STATE_W-1:0]                  act_target;
    logic [SP_W-1:0]                     pops_ext;
    logic [SP_W-1:0]                     sp_after_pop;
    logic                                stack_full;

    assign in_addr = s_axis_tdata[15:0];
    assign in_word = s_axis_tdata[40:16];
    assign in_tok  = s_axis_tdata[47:41];
    assign in_op   = lrsr_pkg::opcode_t'(s_axis_tuser);

    assign act_kind   = lrsr_pkg::kind_t'(tbl_rdata[1:0]);
    assign act_target = tbl_rdata[2 +: STATE_W];
    assign act_acc    = tbl_rdata[2];
    assign act_pops   = tbl_rdata[7:3];
    assign act_lhs    = tbl_rdata[14:8];
    assign act_rule   = tbl_rdata[24:15];
    assign pops_ext   = SP_W'(act_pops);
    assign sp_after_pop = sp_reg - pops_ext;
    assign stack_full = (sp_reg >= SP_W'(lrsr_pkg::STACK_DEPTH));

    assign s_axis_tready = (state_reg == ST_IDLE) && !clr_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            lrsr_pkg::REG_START_STATE:  prdata = 32'(start_state_reg);
            lrsr_pkg::REG_REDUCE_LIMIT: prdata = 32'(reduce_limit_reg);
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_state_reg  <= '0;
            reduce_limit_reg <= lrsr_pkg::LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                lrsr_pkg::REG_START_STATE:  start_state_reg  <= pwdata[STATE_W-1:0];
                lrsr_pkg::REG_REDUCE_LIMIT: reduce_limit_reg <= pwdata[lrsr_pkg::LIMIT_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        running_next  = running_reg;
        sp_next       = sp_reg;
        top_next      = top_reg;
        done_next     = done_reg;
        tok_next      = tok_reg;
        rule_next     = rule_reg;
        pops_next     = pops_reg;
        lhs_next      = lhs_reg;
        acc_next      = acc_reg;

        tbl_wr_en   = 1'b0;
        tbl_wr_addr = in_addr[TBL_AW-1:0];
        tbl_wr_data = in_word;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = {top_reg, tok_reg};
        stk_wr_en   = 1'b0;
        stk_wr_addr = sp_reg[STK_AW-1:0];
        stk_wr_data = act_target;
        stk_rd_en   = 1'b0;
        stk_rd_addr = STK_AW'(sp_after_pop - SP_W'(1));

        emit   = 1'b0;
        e_ev   = lrsr_pkg::EV_SYNTAX;
        e_rule = '0;
        e_pops = '0;
        e_sym  = tok_reg;
        e_last = 1'b1;

        if (clr_reg)
        begin
            tbl_wr_en     = 1'b1;
            tbl_wr_addr   = clr_addr_reg;
            tbl_wr_data   = '0;
            clr_addr_next = clr_addr_reg + TBL_AW'(1);
            if (clr_addr_reg == TBL_AW'(lrsr_pkg::TABLE_SIZE - 1))
            begin
                clr_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_op)
                        lrsr_pkg::OP_WRITE:
                        begin
                            tbl_wr_en = 1'b1;
                        end
                        lrsr_pkg::OP_RESTART:
                        begin
                            stk_wr_en    = 1'b1;
                            stk_wr_addr  = '0;
                            stk_wr_data  = start_state_reg;
                            sp_next      = SP_W'(1);
                            top_next     = start_state_reg;
                            running_next = 1'b1;
                        end
                        lrsr_pkg::OP_TOKEN:
                        begin
                            tok_next   = in_tok;
                            done_next  = '0;
                            state_next = ST_LOOK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOK:
            begin
                if (!running_reg)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        e_ev       = lrsr_pkg::EV_IDLE;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    tbl_rd_en  = 1'b1;
                    state_next = ST_ACT;
                end
            end
            ST_ACT:
            begin
                case (act_kind)
                    lrsr_pkg::KIND_SHIFT:
                    begin
                        if (out_free)
                        begin
                            emit       = 1'b1;
                            state_next = ST_IDLE;
                            if (stack_full)
                            begin
                                e_ev         = lrsr_pkg::EV_OVERFLOW;
                                running_next = 1'b0;
                            end
                            else
                            begin
                                e_ev      = lrsr_pkg::EV_SHIFT;
                                stk_wr_en = 1'b1;
                                sp_next   = sp_reg + SP_W'(1);
                                top_next  = act_target;
                            end
                        end
                    end
                    lrsr_pkg::KIND_REDUCE:
                    begin
                        rule_next = act_rule;
                        pops_next = act_pops;
                        lhs_next  = act_lhs;
                        acc_next  = act_acc;
                        if (done_reg >= reduce_limit_reg)
                        begin
                            if (out_free)
                            begin
                                emit         = 1'b1;
                                e_ev         = lrsr_pkg::EV_LIMIT;
                                running_next = 1'b0;
                                state_next   = ST_IDLE;
                            end
                        end
                        else if (pops_ext > sp_reg || (!act_acc && pops_ext == sp_reg))
                        begin
                            if (out_free)
                            begin
                                emit         = 1'b1;
                                e_ev         = lrsr_pkg::EV_UNDERFLOW;
                                e_rule       = act_rule;
                                e_pops       = act_pops;
                                e_sym        = act_lhs;
                                running_next = 1'b0;
                                state_next   = ST_IDLE;
                            end
                        end
                        else
                        begin
                            sp_next    = sp_after_pop;
                            stk_rd_en  = (sp_after_pop != '0);
                            state_next = ST_TOP;
                        end
                    end
                    default:
                    begin
                        if (out_free)
                        begin
                            emit         = 1'b1;
                            e_ev         = lrsr_pkg::EV_SYNTAX;
                            running_next = 1'b0;
                            state_next   = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_TOP:
            begin
                e_rule = rule_reg;
                e_pops = pops_reg;
                e_sym  = lhs_reg;
                if (acc_reg)
                begin
                    if (out_free)
                    begin
                        emit         = 1'b1;
                        e_ev         = lrsr_pkg::EV_ACCEPT;
                        top_next     = (sp_reg == '0) ? '0 : stk_rdata;
                        running_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    top_next    = stk_rdata;
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = {stk_rdata, lhs_reg};
                    state_next  = ST_GOTO;
                end
            end
            ST_GOTO:
            begin
                e_rule = rule_reg;
                e_pops = pops_reg;
                e_sym  = lhs_reg;
                if (out_free)
                begin
                    emit = 1'b1;
                    if (act_kind != lrsr_pkg::KIND_GOTO)
                    begin
                        e_ev         = lrsr_pkg::EV_SYNTAX;
                        running_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else if (stack_full)
                    begin
                        e_ev         = lrsr_pkg::EV_OVERFLOW;
                        running_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        e_ev       = lrsr_pkg::EV_REDUCE;
                        e_last     = 1'b0;
                        stk_wr_en  = 1'b1;
                        sp_next    = sp_reg + SP_W'(1);
                        top_next   = act_target;
                        done_next  = done_reg + lrsr_pkg::LIMIT_W'(1);
                        state_next = ST_LOOK;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            running_reg  <= 1'b0;
            sp_reg       <= '0;
            top_reg      <= '0;
            done_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            running_reg  <= running_next;
            sp_reg       <= sp_next;
            top_reg      <= top_next;
            done_reg     <= done_next;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg  <= tok_next;
        rule_reg <= rule_next;
        pops_reg <= pops_next;
        lhs_reg  <= lhs_next;
        acc_reg  <= acc_next;
        if (emit)
        begin
            m_data_reg <= {SP_W'(sp_next), top_next, e_sym, e_pops, e_rule};
            m_user_reg <= e_ev;
            m_last_reg <= e_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr_en)
        begin
            tbl_mem[tbl_wr_addr] <= tbl_wr_data;
        end
        if (tbl_rd_en)
        begin
            tbl_rdata <= tbl_mem[tbl_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_wr_en)
        begin
            stk_mem[stk_wr_addr] <= stk_wr_data;
        end
        if (stk_rd_en)
        begin
            stk_rdata <= stk_mem[stk_rd_addr];
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

@@ tb/sv/lr_parse_checker.sv @@
// Checker for the LR shift-reduce engine: keeps its own action table, state stack
// and register copies, predicts the results of each accepted item and compares them
// in order with the results leaving the engine. Depends on lrsr_pkg.
module lr_parse_checker
    import lrsr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic                pready,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    input  logic [1:0]          s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [M_DATA_W-1:0] m_axis_tdata,
    input  logic [2:0]          m_axis_tuser,
    input  logic                m_axis_tlast,
    output int                  fail_count,
    output int                  pending,
    output logic                parse_active
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        event_t              ev;
        logic [RULE_W-1:0]   rule;
        logic [POPS_W-1:0]   pops;
        logic [FSYM_W-1:0]   sym;
        logic [FSTATE_W-1:0] top_state;
        logic [FSTATE_W-1:0] stack_level;
        logic                last;
    } parse_event_t;

    logic [WORD_W-1:0]   parse_table [TABLE_SIZE];
    logic [FSTATE_W-1:0] state_stack [STACK_DEPTH];
    int                  stack_depth;
    logic                running;
    logic [FSTATE_W-1:0] start_state;
    logic [LIMIT_W-1:0]  reduce_limit;
    parse_event_t        expected_events [$];

    function automatic logic [FSTATE_W-1:0] stack_top();
        return (stack_depth == 0) ? '0 : state_stack[stack_depth-1];
    endfunction

    function automatic void log_event(event_t ev, logic [RULE_W-1:0] rule,
                                      logic [POPS_W-1:0] pops, logic [FSYM_W-1:0] sym,
                                      logic last);
        parse_event_t e;
        e.ev          = ev;
        e.rule        = rule;
        e.pops        = pops;
        e.sym         = sym;
        e.top_state   = stack_top();
        e.stack_level = FSTATE_W'(stack_depth);
        e.last        = last;
        expected_events.insert(expected_events.size(), e);
    endfunction

    function automatic void stop_parse(event_t ev, logic [RULE_W-1:0] rule,
                                       logic [POPS_W-1:0] pops, logic [FSYM_W-1:0] sym);
        running = 1'b0;
        log_event(ev, rule, pops, sym, 1'b1);
    endfunction

    function automatic void predict_token(logic [FSYM_W-1:0] tok);
        logic [WORD_W-1:0]   entry;
        logic [WORD_W-1:0]   go_entry;
        logic                acc;
        logic [POPS_W-1:0]   pops;
        logic [FSYM_W-1:0]   lhs;
        logic [RULE_W-1:0]   rule;
        if (!running)
        begin
            log_event(EV_IDLE, '0, '0, tok, 1'b1);
            return;
        end
        for (int chain = 0; chain < (1 << LIMIT_W); chain++)
        begin
            entry = parse_table[{stack_top(), tok}];
            if (entry[1:0] == KIND_SHIFT)
            begin
                if (stack_depth >= STACK_DEPTH)
                begin
                    stop_parse(EV_OVERFLOW, '0, '0, tok);
                    return;
                end
                state_stack[stack_depth] = entry[10:2];
                stack_depth++;
                log_event(EV_SHIFT, '0, '0, tok, 1'b1);
                return;
            end
            if (entry[1:0] != KIND_REDUCE)
            begin
                stop_parse(EV_SYNTAX, '0, '0, tok);
                return;
            end
            if (chain >= int'(reduce_limit))
            begin
                stop_parse(EV_LIMIT, '0, '0, tok);
                return;
            end
            acc  = entry[2];
            pops = entry[7:3];
            lhs  = entry[14:8];
            rule = entry[24:15];
            if (int'(pops) > stack_depth || (!acc && int'(pops) == stack_depth))
            begin
                stop_parse(EV_UNDERFLOW, rule, pops, lhs);
                return;
            end
            stack_depth -= int'(pops);
            if (acc)
            begin
                stop_parse(EV_ACCEPT, rule, pops, lhs);
                return;
            end
            go_entry = parse_table[{stack_top(), lhs}];
            if (go_entry[1:0] != KIND_GOTO)
            begin
                stop_parse(EV_SYNTAX, rule, pops, lhs);
                return;
            end
            if (stack_depth >= STACK_DEPTH)
            begin
                stop_parse(EV_OVERFLOW, rule, pops, lhs);
                return;
            end
            state_stack[stack_depth] = go_entry[10:2];
            stack_depth++;
            log_event(EV_REDUCE, rule, pops, lhs, 1'b0);
        end
    endfunction

    function automatic string event_text(parse_event_t e);
        return $sformatf("event %0d rule %0d pops %0d symbol %0d top %0d level %0d last %0d",
                         e.ev, e.rule, e.pops, e.sym, e.top_state, e.stack_level, e.last);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        parse_event_t got;
        parse_event_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
                parse_table[i] = '0;
            stack_depth  = 0;
            running      = 1'b0;
            start_state  = '0;
            reduce_limit = LIMIT_RESET;
            expected_events.delete();
            fail_count   = 0;
            pending      = 0;
            parse_active = 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_REDUCE_LIMIT)
                    reduce_limit = pwdata[LIMIT_W-1:0];
                else
                    start_state = pwdata[FSTATE_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                case (s_axis_tuser)
                    OP_WRITE:
                        parse_table[s_axis_tdata[ADDR_W-1:0]] = s_axis_tdata[ADDR_W +: WORD_W];
                    OP_RESTART:
                    begin
                        state_stack[0] = start_state;
                        stack_depth    = 1;
                        running        = 1'b1;
                    end
                    OP_TOKEN:
                        predict_token(s_axis_tdata[ADDR_W+WORD_W +: FSYM_W]);
                    default:
                        ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.ev          = event_t'(m_axis_tuser);
                got.rule        = m_axis_tdata[0 +: RULE_W];
                got.pops        = m_axis_tdata[RULE_W +: POPS_W];
                got.sym         = m_axis_tdata[RULE_W+POPS_W +: FSYM_W];
                got.top_state   = m_axis_tdata[RULE_W+POPS_W+FSYM_W +: FSTATE_W];
                got.stack_level = m_axis_tdata[RULE_W+POPS_W+FSYM_W+FSTATE_W +: FSTATE_W];
                got.last        = m_axis_tlast;
                if (expected_events.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %s",
                             $time, event_text(got));
                end
                else
                begin
                    want = expected_events.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        $display("%0t: result mismatch, expected %s, actual %s",
                                 $time, event_text(want), event_text(got));
                    end
                end
            end
            pending      = expected_events.size();
            parse_active = running;
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
// Top of the LR shift-reduce engine testbench: clock, reset, register writes and
// item stimulus with random idling, plus the final verdict.
// Depends on lrsr_pkg, lr_shift_reduce_engine and lr_parse_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lrsr_pkg::*;

    localparam int         CYCLE_LIMIT   = 1_000_000;
    localparam int         IDLE_PCT      = 7;
    localparam int         SETTLE_CYCLES = 8;
    localparam int         TAIL_CYCLES   = 300;
    localparam logic [1:0] OP_UNUSED     = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic [1:0]          s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic [2:0]          m_axis_tuser;
    logic                m_axis_tlast;

    int                  fail_count;
    int                  pending;
    logic                parse_active;
    logic                idling = 1'b1;
    int                  cycle_count;

    lr_shift_reduce_engine u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lr_parse_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .parse_active  (parse_active)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        m_axis_tready <= !(idling && $urandom_range(99) < IDLE_PCT);

    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [WORD_W-1:0] jump_word(kind_t kind, logic [FSTATE_W-1:0] target);
        logic [WORD_W-1:0] w;
        w       = WORD_W'($urandom);
        w[10:2] = target;
        w[1:0]  = kind;
        return w;
    endfunction

    function automatic logic [WORD_W-1:0] reduce_word(logic acc, logic [POPS_W-1:0] pops,
                                                      logic [FSYM_W-1:0] lhs,
                                                      logic [RULE_W-1:0] rule);
        return {rule, lhs, pops, acc, KIND_REDUCE};
    endfunction

    function automatic logic [WORD_W-1:0] random_action(logic [FSTATE_W-1:0] target,
                                                        logic [FSYM_W-1:0] lhs);
        int                pick;
        logic [WORD_W-1:0] w;
        pick = $urandom_range(99);
        if (pick < 40)
            return jump_word(KIND_SHIFT, target);
        if (pick < 80)
            return reduce_word($urandom_range(9) == 0,
                               ($urandom_range(7) == 0) ? POPS_W'($urandom)
                                                        : POPS_W'($urandom_range(2)),
                               lhs, RULE_W'($urandom));
        if (pick < 90)
            return jump_word(KIND_GOTO, target);
        w      = WORD_W'($urandom);
        w[1:0] = KIND_NONE;
        return w;
    endfunction

    task automatic reg_write(logic reg_index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic put_item(logic [1:0] op, logic [ADDR_W-1:0] addr,
                            logic [WORD_W-1:0] word, logic [FSYM_W-1:0] tok);
        while (idling && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tok, word, addr};
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_token(logic [FSYM_W-1:0] tok);
        put_item(OP_TOKEN, ADDR_W'($urandom), WORD_W'($urandom), tok);
    endtask

    task automatic restart_parse();
        put_item(OP_RESTART, ADDR_W'($urandom), WORD_W'($urandom), FSYM_W'($urandom));
    endtask

    task automatic write_entry(logic [FSTATE_W-1:0] st, logic [FSYM_W-1:0] sym,
                               logic [WORD_W-1:0] word);
        put_item(OP_WRITE, {st, sym}, word, FSYM_W'($urandom));
    endtask

    task automatic drain(int settle);
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (settle)
            @(negedge clk);
    endtask

    task automatic directed_checks();
        logic [FSTATE_W-1:0] st;
        st = FSTATE_W'(STATE_COUNT - 1);
        send_token(FSYM_W'(SYMBOL_COUNT - 1));
        put_item(OP_UNUSED, '1, '1, '1);
        write_entry(st, 7'd5, reduce_word(1'b0, 5'd1, 7'd127, 10'd1023));
        write_entry(st, 7'd1, jump_word(KIND_GOTO, 9'd3));
        write_entry(st, 7'd2, jump_word(KIND_SHIFT, 9'd0));
        write_entry(st, 7'd127, jump_word(KIND_GOTO, 9'd1));
        write_entry(9'd0, 7'd3, reduce_word(1'b0, 5'd1, 7'd127, 10'd1023));
        write_entry(9'd0, 7'd4, reduce_word(1'b0, 5'd1, 7'd5, 10'd5));
        write_entry(9'd0, 7'd6, reduce_word(1'b0, 5'd1, 7'd127, 10'd0));
        write_entry(9'd1, 7'd3, reduce_word(1'b1, 5'd2, 7'd0, 10'd0));
        write_entry(9'd1, 7'd6, reduce_word(1'b0, 5'd0, 7'd9, 10'd7));
        write_entry(9'd1, 7'd9, jump_word(KIND_GOTO, 9'd1));
        restart_parse();
        send_token(7'd5);
        restart_parse();
        send_token(7'd0);
        restart_parse();
        send_token(7'd1);
        restart_parse();
        send_token(7'd2);
        send_token(7'd3);
        send_token(7'd3);
        restart_parse();
        send_token(7'd2);
        send_token(7'd4);
        restart_parse();
        send_token(7'd2);
        send_token(7'd6);
    endtask

    task automatic grammar_phase(logic [FSTATE_W-1:0] start, logic [LIMIT_W-1:0] limit,
                                 int tokens);
        logic [FSTATE_W-1:0] states [3];
        logic [FSYM_W-1:0]   terms [3];
        logic [FSYM_W-1:0]   nonterms [2];
        logic [FSYM_W-1:0]   tok;
        int                  pick;
        drain(SETTLE_CYCLES);
        reg_write(REG_START_STATE, 32'(start));
        reg_write(REG_REDUCE_LIMIT, 32'(limit));
        states[0] = start;
        for (int i = 1; i < 3; i++)
            states[i] = FSTATE_W'($urandom);
        foreach (terms[i])
            terms[i] = FSYM_W'($urandom);
        foreach (nonterms[i])
            nonterms[i] = FSYM_W'($urandom);
        foreach (states[s])
            foreach (terms[t])
                write_entry(states[s], terms[t],
                            random_action(states[$urandom_range(2)], nonterms[$urandom_range(1)]));
        foreach (states[s])
            foreach (nonterms[n])
                write_entry(states[s], nonterms[n],
                            ($urandom_range(99) < 85) ?
                            jump_word(KIND_GOTO, states[$urandom_range(2)]) : WORD_W'($urandom));
        for (int n = 0; n < tokens; n++)
        begin
            pick = $urandom_range(99);
            if (!parse_active ? pick < 90 : pick < 5)
                restart_parse();
            else if (pick < 8)
                put_item(OP_UNUSED, ADDR_W'($urandom), WORD_W'($urandom), FSYM_W'($urandom));
            else if (pick < 11)
                write_entry(states[$urandom_range(2)], terms[$urandom_range(2)],
                            WORD_W'($urandom));
            tok = ($urandom_range(9) == 0) ? FSYM_W'($urandom) : terms[$urandom_range(2)];
            send_token(tok);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_WRITE;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        reg_write(REG_START_STATE, 32'(STATE_COUNT - 1));
        reg_write(REG_REDUCE_LIMIT, 32'(LIMIT_RESET));
        directed_checks();
        grammar_phase('0, '0, 10);
        idling = 1'b0;
        grammar_phase(FSTATE_W'($urandom), LIMIT_W'(1), 10);
        idling = 1'b1;
        grammar_phase(FSTATE_W'(STATE_COUNT - 1), LIMIT_W'($urandom_range(63, 2)), 10);
        drain(TAIL_CYCLES);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
